FILE: sv/lru_k_replacement_policy_assert.svh
// assertion macros for the lru-k replacement policy
`ifndef LRU_K_REPLACEMENT_POLICY_ASSERT_SVH
`define LRU_K_REPLACEMENT_POLICY_ASSERT_SVH
`ifndef SYNTH
`define LKRP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("lkrp assertion failed");
`define LKRP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("lkrp implication failed");
`else
`define LKRP_ASSERT(lbl, prop)
`define LKRP_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

FILE: sv/lkrp_pkg.sv
// types and constants of the lru-k replacement policy
`timescale 1ns / 1ps
package lkrp_pkg;
	localparam int MAX_FRAMES  = 64;
	localparam int MAX_K       = 8;
	localparam int STAMP_WIDTH = 32;
	localparam int FRAME_W     = $clog2(MAX_FRAMES);
	localparam int HEAD_W      = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int CNT_W       = $clog2(MAX_K + 1);
	localparam int HIST_AW     = FRAME_W + HEAD_W;
	localparam int TOTAL_W     = 7;
	localparam int FC_W        = 7;
	localparam int KD_W        = 4;

	typedef enum logic [1:0] {
		CMD_RECORD = 2'd0,
		CMD_SET    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_EVICT  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_OK     = 2'd0,
		ERR_RANGE  = 2'd1,
		ERR_PINNED = 2'd2
	} err_t;

	typedef enum logic {
		REG_FRAME_COUNT = 1'b0,
		REG_K_DEPTH     = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_META,
		ST_SCAN,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [FRAME_W-1:0] frame_index;
		logic               make_evictable;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] victim_frame;
		logic               victim_valid;
		logic [1:0]         error_code;
		logic [TOTAL_W-1:0] evictable_count;
	} rsp_t;

	typedef struct packed {
		logic              present;
		logic              evictable;
		logic [CNT_W-1:0]  cnt;
		logic [HEAD_W-1:0] head;
	} meta_t;
endpackage

FILE: sv/lkrp_meta_mem.sv
// per-frame mark, count and head memory with reset valid bits
`timescale 1ns / 1ps
module lkrp_meta_mem import lkrp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [FRAME_W-1:0] rd_addr,
	output meta_t              rd_data,
	input  logic               wr_en,
	input  logic [FRAME_W-1:0] wr_addr,
	input  meta_t              wr_data,
	input  logic               clr_en,
	input  logic [FRAME_W-1:0] clr_addr
);
	meta_t mem [MAX_FRAMES];
	meta_t rd_q;
	logic [MAX_FRAMES-1:0] vld_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (clr_en) begin
				vld_q[clr_addr] <= 1'b0;
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;
endmodule

FILE: sv/lkrp_hist_mem.sv
// access stamp history memory, one read and one write port
`timescale 1ns / 1ps
module lkrp_hist_mem import lkrp_pkg::*; (
	input  logic                   clk,
	input  logic [HIST_AW-1:0]     rd_addr,
	output logic [STAMP_WIDTH-1:0] rd_data,
	input  logic                   wr_en,
	input  logic [HIST_AW-1:0]     wr_addr,
	input  logic [STAMP_WIDTH-1:0] wr_data
);
	logic [STAMP_WIDTH-1:0] mem [MAX_FRAMES*MAX_K];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

FILE: sv/lru_k_replacement_policy.sv
// lru-k replacement policy top level: control, scan and response register
// record, set and remove pass from the request through the meta and response states; out of range skips meta
// evict scans one frame a cycle over all MAX_FRAMES frames, then passes to the response state
// one request at a time; the next is taken while a result waits in the output register
// reset clears all marks, counts, the timestamp and the evictable total; frame_count 64, k 2
`timescale 1ns / 1ps
`include "lru_k_replacement_policy_assert.svh"
module lru_k_replacement_policy import lkrp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  req_t              in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rsp_t              out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [FC_W-1:0]   cfg_data
);
	state_t state_q, state_d;
	logic [1:0]             cmd_q;
	logic [FRAME_W-1:0]     frm_q;
	logic                   mark_q;
	logic [STAMP_WIDTH-1:0] ts_q, ts_d;
	logic [TOTAL_W-1:0]     total_q, total_d;
	logic [FC_W-1:0]        fc_q;
	logic [KD_W-1:0]        kd_q;
	rsp_t                   rsp_q, rsp_d;
	logic                   out_valid_q;
	rsp_t                   out_q;

	logic [FRAME_W:0]       idx_q;
	logic                   v_s1, v_s2;
	logic [FRAME_W-1:0]     frm_s1, frm_s2;
	logic                   elig_s2, reach_s2;
	logic                   fnd0_q, fnd1_q;
	logic [STAMP_WIDTH-1:0] best0_q, best1_q;
	logic [FRAME_W-1:0]     vic0_q, vic1_q;

	logic [KD_W-1:0]        k_eff;
	logic [FRAME_W-1:0]     meta_rd_addr;
	meta_t                  meta_rd;
	logic                   meta_wr_en, clr_en;
	meta_t                  meta_wr, base;
	logic [FRAME_W-1:0]     clr_addr;
	logic [HIST_AW-1:0]     hist_rd_addr, hist_wr_addr;
	logic [STAMP_WIDTH-1:0] hist_rd;
	logic                   hist_wr_en;
	logic                   reach_s1;
	logic [KD_W-1:0]        n_s1;
	logic                   issue, scan_done, found;
	logic [STAMP_WIDTH-1:0] stamp_max;

	assign stamp_max = '1;
	assign k_eff = (kd_q == '0) ? KD_W'(1) : ((kd_q > KD_W'(MAX_K)) ? KD_W'(MAX_K) : kd_q);
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign issue        = (state_q == ST_SCAN) && !idx_q[FRAME_W];
	assign scan_done    = (state_q == ST_SCAN) && idx_q[FRAME_W] && !v_s1 && !v_s2;
	assign meta_rd_addr = (state_q == ST_IDLE) ? in_data.frame_index : idx_q[FRAME_W-1:0];

	// history position of the k-th most recent stamp, or of the oldest when fewer than k are recorded
	assign reach_s1     = KD_W'(meta_rd.cnt) >= k_eff;
	assign n_s1         = reach_s1 ? k_eff : KD_W'(meta_rd.cnt);
	assign hist_rd_addr = {frm_s1, meta_rd.head - n_s1[HEAD_W-1:0]};

	assign base  = meta_rd.present ? meta_rd : '{present: 1'b1, evictable: 1'b0,
		cnt: '0, head: '0};
	assign found = fnd0_q || fnd1_q;

	lkrp_meta_mem u_meta (
		.clk(clk), .arst_n(arst_n),
		.rd_addr(meta_rd_addr), .rd_data(meta_rd),
		.wr_en(meta_wr_en), .wr_addr(frm_q), .wr_data(meta_wr),
		.clr_en(clr_en), .clr_addr(clr_addr)
	);

	lkrp_hist_mem u_hist (
		.clk(clk),
		.rd_addr(hist_rd_addr), .rd_data(hist_rd),
		.wr_en(hist_wr_en), .wr_addr(hist_wr_addr), .wr_data(ts_q)
	);

	always_comb begin
		state_d      = state_q;
		ts_d         = ts_q;
		total_d      = total_q;
		rsp_d        = rsp_q;
		meta_wr_en   = 1'b0;
		meta_wr      = base;
		clr_en       = 1'b0;
		clr_addr     = frm_q;
		hist_wr_en   = 1'b0;
		hist_wr_addr = {frm_q, base.head};
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					rsp_d = '0;
					rsp_d.evictable_count = total_q;
					if (in_data.command == CMD_EVICT) begin
						state_d = ST_SCAN;
					end else if ({1'b0, in_data.frame_index} >= fc_q) begin
						rsp_d.error_code = ERR_RANGE;
						state_d = ST_RESP;
					end else begin
						state_d = ST_META;
					end
				end
			end
			ST_META: begin
				unique case (cmd_q)
					CMD_RECORD: begin
						hist_wr_en   = 1'b1;
						meta_wr_en   = 1'b1;
						meta_wr.head = base.head + 1'b1;
						if (base.cnt < CNT_W'(MAX_K)) begin
							meta_wr.cnt = base.cnt + 1'b1;
						end
						if (ts_q != stamp_max) begin
							ts_d = ts_q + 1'b1;
						end
					end
					CMD_SET: begin
						meta_wr = meta_rd;
						meta_wr.evictable = mark_q;
						if (meta_rd.present && meta_rd.evictable != mark_q) begin
							meta_wr_en = 1'b1;
							if (mark_q) begin
								total_d = total_q + 1'b1;
							end else if (total_q != '0) begin
								total_d = total_q - 1'b1;
							end
						end
					end
					CMD_REMOVE: begin
						if (meta_rd.present) begin
							if (!meta_rd.evictable) begin
								rsp_d.error_code = ERR_PINNED;
							end else begin
								clr_en = 1'b1;
								if (total_q != '0) begin
									total_d = total_q - 1'b1;
								end
							end
						end
					end
					default: begin
					end
				endcase
				rsp_d.evictable_count = total_d;
				state_d = ST_RESP;
			end
			ST_SCAN: begin
				if (scan_done) begin
					if (found) begin
						clr_en   = 1'b1;
						clr_addr = fnd0_q ? vic0_q : vic1_q;
						rsp_d.victim_frame = clr_addr;
						rsp_d.victim_valid = 1'b1;
						if (total_q != '0) begin
							total_d = total_q - 1'b1;
						end
					end
					rsp_d.evictable_count = total_d;
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ts_q        <= '0;
			total_q     <= '0;
			fc_q        <= FC_W'(64);
			kd_q        <= KD_W'(2);
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			fnd0_q      <= 1'b0;
			fnd1_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			ts_q    <= ts_d;
			total_q <= total_d;
			if (cfg_valid && cfg_index[1] == 1'b0) begin
				if (cfg_index[0] == REG_FRAME_COUNT) begin
					fc_q <= cfg_data;
				end else begin
					kd_q <= cfg_data[KD_W-1:0];
				end
			end
			if (state_q == ST_RESP && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_IDLE && in_valid) begin
				idx_q  <= '0;
				fnd0_q <= 1'b0;
				fnd1_q <= 1'b0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (v_s2 && elig_s2) begin
				if (!reach_s2 && (!fnd0_q || hist_rd < best0_q)) begin
					fnd0_q <= 1'b1;
				end
				if (reach_s2 && (!fnd1_q || hist_rd < best1_q)) begin
					fnd1_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q  <= in_data.command;
			frm_q  <= in_data.frame_index;
			mark_q <= in_data.make_evictable;
		end
		if (state_q == ST_RESP && (!out_valid_q || out_ready)) begin
			out_q <= rsp_q;
		end
		frm_s1   <= idx_q[FRAME_W-1:0];
		frm_s2   <= frm_s1;
		elig_s2  <= meta_rd.present && meta_rd.evictable;
		reach_s2 <= reach_s1;
		if (v_s2 && elig_s2) begin
			if (!reach_s2 && (!fnd0_q || hist_rd < best0_q)) begin
				best0_q <= hist_rd;
				vic0_q  <= frm_s2;
			end
			if (reach_s2 && (!fnd1_q || hist_rd < best1_q)) begin
				best1_q <= hist_rd;
				vic1_q  <= frm_s2;
			end
		end
	end

	`LKRP_ASSERT(a_total_range, total_q <= TOTAL_W'(MAX_FRAMES))
	`LKRP_ASSERT_IMPL(a_victim_ok, out_valid && out_data.victim_valid, out_data.error_code == ERR_OK)
	`LKRP_ASSERT_IMPL(a_scan_idle_in, state_q == ST_SCAN, !in_ready)
endmodule
